### rtl/core/olisd_pkg.sv
// Package for the ordered list block: command and status codes, and the
// command and status groups that pass between controller and datapath.
// No dependencies.
package olisd_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;        // load key and rewind the walk
        logic append;       // write the value at the tail
        logic step;         // advance the read walk by one entry
        logic shift_start;  // restart the walk just past the matching entry
        logic shift_write;  // write back each read entry one place lower
        logic dec;          // one entry fewer
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic               full;
        logic               rd_valid;
        logic               match;
        logic               walk_end;
        logic [COUNT_W-1:0] count;
    } t_dp_sts;

endpackage

### rtl/core/olisd_if.sv
// Request and response channel interfaces of the ordered list block.
// Depends on olisd_pkg for the field widths.
interface olisd_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           command;
    logic signed [olisd_pkg::VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

interface olisd_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               found;
    logic [1:0]                         status;
    logic [olisd_pkg::COUNT_W-1:0]      entry_count;

    modport source (output valid, output found, output status, output entry_count,
                    input ready);
    modport sink (input valid, input found, input status, input entry_count,
                  output ready);
endinterface

### rtl/core/ordered_list_insert_search_delete.sv
// Top level of the ordered list block: joins the command controller and the
// list datapath. Depends on olisd_pkg, olisd_if, olisd_ctrl, olisd_datapath.
//
//   Channel   Direction  Fields                         Handshake
//   i_req     in         command[1:0], value[31:0] s    valid / ready
//   o_rsp     out        found, status[1:0],            valid / ready
//                        entry_count[4:0]
//
// One request is handled at a time. Append and the unused command code go
// from acceptance through the finishing state to a loaded response. Search
// walks the entries until a match or the end of the list; delete walks them
// and then shifts the later entries down, and the walk and the shift read the
// single entry memory once per cycle. Reset is synchronous and clears the
// entry count, the state machine and the response valid; the entry memory is
// not cleared. The next request is taken while a response still waits in the
// response register; a stalled response only holds the block once the
// following command has finished.
module ordered_list_insert_search_delete #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olisd_req_if.sink   i_req,
    olisd_rsp_if.source o_rsp
);
    import olisd_pkg::*;

    // Command and status groups between the sequencer and the datapath.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller decides, per cycle, which datapath action takes place
    // and holds the result of the command until the response slot is free.
    olisd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // The datapath holds the entries in arrival order and walks them with a
    // registered read, comparing each against the key, then closes the gap
    // after a deleted entry by writing each later entry one place lower.
    olisd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_req.value),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts)
    );

endmodule

### rtl/core/olisd_datapath.sv
// Datapath of the ordered list block: entry memory, entry count, key and the
// read and write pointers of the list walk. Depends on olisd_pkg.
module olisd_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [olisd_pkg::VALUE_W-1:0] i_value,
    input  olisd_pkg::t_dp_cmd                   i_cmd,
    output olisd_pkg::t_dp_sts                   o_sts
);
    import olisd_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] r_mem [CAPACITY];
    logic [VALUE_W-1:0] r_rdata;
    logic [VALUE_W-1:0] r_key;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_rd;
    logic [AW-1:0]      r_wr;
    logic [AW-1:0]      r_ci;
    logic               r_rv;

    logic               rd_en;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;

    assign rd_en = i_cmd.step && !i_cmd.start && !i_cmd.shift_start && (r_rd < r_count);
    assign we    = i_cmd.append || (i_cmd.shift_write && r_rv);
    assign waddr = i_cmd.append ? r_count[AW-1:0] : r_wr;
    assign wdata = i_cmd.append ? VALUE_W'(i_value) : r_rdata;

    // Memory with one write port and one read port: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_rd[AW-1:0]];
            r_ci    <= r_rd[AW-1:0];
        end
        if (i_cmd.start) begin
            r_key <= VALUE_W'(i_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_rv    <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_rd <= '0;
                r_rv <= 1'b0;
            end else if (i_cmd.shift_start) begin
                r_wr <= r_ci;
                r_rd <= CW'(r_ci) + CW'(1);
                r_rv <= 1'b0;
            end else if (i_cmd.step) begin
                r_rv <= rd_en;
                if (rd_en) begin
                    r_rd <= r_rd + CW'(1);
                end
                if (i_cmd.shift_write && r_rv) begin
                    r_wr <= r_wr + AW'(1);
                end
            end
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.rd_valid = r_rv;
    assign o_sts.match    = (r_rdata == r_key);
    assign o_sts.walk_end = !r_rv && (r_rd >= r_count);
    assign o_sts.count    = COUNT_W'(r_count);

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_count < CW'(CAPACITY)))
        else $error("append issued with the list full");

    a_dec_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dec |-> (r_count != '0))
        else $error("entry removed from an empty list");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift_write && r_rv) |-> ((CW'(r_wr) + CW'(1)) < r_count))
        else $error("shift write beyond the last held entry");

endmodule

### rtl/core/olisd_ctrl.sv
// Controller of the ordered list block: command sequencing state machine
// and the response register. Depends on olisd_pkg and olisd_if.
module olisd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    olisd_req_if.sink          i_req,
    olisd_rsp_if.source        o_rsp,
    input  olisd_pkg::t_dp_sts i_sts,
    output olisd_pkg::t_dp_cmd o_cmd
);
    import olisd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic               r_del, n_del;
    logic               r_found, n_found;
    t_status            r_status, n_status;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    t_status            r_out_status, n_out_status;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    t_dp_cmd            cmd;

    always_comb begin
        n_state      = r_state;
        n_del        = r_del;
        n_found      = r_found;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    cmd.start = 1'b1;
                    n_found   = 1'b0;
                    n_status  = ST_OK;
                    n_del     = 1'b0;
                    unique case (t_cmd'(i_req.command))
                        CMD_APPEND: begin
                            if (i_sts.full) begin
                                n_status = ST_FULL;
                            end else begin
                                cmd.append = 1'b1;
                                n_found    = 1'b1;
                            end
                            n_state = S_FIN;
                        end
                        CMD_SEARCH: begin
                            n_state = S_SCAN;
                        end
                        CMD_DELETE: begin
                            n_del   = 1'b1;
                            n_state = S_SCAN;
                        end
                        CMD_NOP: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                priority if (i_sts.rd_valid && i_sts.match) begin
                    n_found  = 1'b1;
                    n_status = ST_OK;
                    if (r_del) begin
                        cmd.shift_start = 1'b1;
                        n_state         = S_SHIFT;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (i_sts.walk_end) begin
                    n_found  = 1'b0;
                    n_status = ST_MISSING;
                    n_state  = S_FIN;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.walk_end) begin
                    cmd.dec = 1'b1;
                    n_state = S_FIN;
                end else begin
                    cmd.step        = 1'b1;
                    cmd.shift_write = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_found;
                    n_out_status = r_status;
                    n_out_count  = i_sts.count;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_del        <= n_del;
        r_found      <= n_found;
        r_status     <= n_status;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_cmd             = cmd;
    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;

    a_fin_loads_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || o_rsp.ready)) |=> r_out_valid)
        else $error("finished command did not reach the response register");

    a_response_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("response raised outside the finishing state");

    a_busy_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> r_del)
        else $error("shift entered by a command other than delete");

endmodule
